// ===== rtl/gcr62_pkg.sv =====
// shared constants, tables and helpers of the 6-and-2 track encoder
package gcr62_pkg;

  localparam int SECTORS      = 16;
  localparam int SECTOR_BYTES = 256;

  // fixed bytes of one sector besides gap 2 and gap 3
  localparam logic [9:0] FIXED_PER_SECTOR = 10'd363;
  localparam logic [9:0] DATA_NIBBLES     = 10'd342;
  localparam logic [6:0] AUX_NIBBLES      = 7'd86;
  localparam logic [7:0] AUX_STEP         = 8'd86;
  localparam logic [6:0] AUX_LAST_THIRD   = 7'd84;

  // register indexes
  localparam logic [1:0] REG_VOLUME = 2'd0;
  localparam logic [1:0] REG_GAP1   = 2'd1;
  localparam logic [1:0] REG_GAP2   = 2'd2;
  localparam logic [1:0] REG_GAP3   = 2'd3;

  // commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // marks
  localparam logic [7:0] SYNC_BYTE   = 8'hFF;
  localparam logic [7:0] MARK_D5     = 8'hD5;
  localparam logic [7:0] MARK_AA     = 8'hAA;
  localparam logic [7:0] MARK_ADDR   = 8'h96;
  localparam logic [7:0] MARK_DATA   = 8'hAD;
  localparam logic [7:0] MARK_DE     = 8'hDE;
  localparam logic [7:0] MARK_EB     = 8'hEB;
  localparam logic [7:0] ODD_EVEN_M  = 8'h55;

  localparam logic [7:0] RST_VOLUME = 8'd254;
  localparam logic [7:0] RST_GAP1   = 8'd48;
  localparam logic [7:0] RST_GAP2   = 8'd6;
  localparam logic [7:0] RST_GAP3   = 8'd27;

  localparam logic [7:0] GCR_TABLE [64] = '{
    8'h96,8'h97,8'h9A,8'h9B,8'h9D,8'h9E,8'h9F,8'hA6,
    8'hA7,8'hAB,8'hAC,8'hAD,8'hAE,8'hAF,8'hB2,8'hB3,
    8'hB4,8'hB5,8'hB6,8'hB7,8'hB9,8'hBA,8'hBB,8'hBC,
    8'hBD,8'hBE,8'hBF,8'hCB,8'hCD,8'hCE,8'hCF,8'hD3,
    8'hD6,8'hD7,8'hD9,8'hDA,8'hDB,8'hDC,8'hDD,8'hDE,
    8'hDF,8'hE5,8'hE6,8'hE7,8'hE9,8'hEA,8'hEB,8'hEC,
    8'hED,8'hEE,8'hEF,8'hF2,8'hF3,8'hF4,8'hF5,8'hF6,
    8'hF7,8'hF9,8'hFA,8'hFB,8'hFC,8'hFD,8'hFE,8'hFF
  };

  localparam logic [3:0] INTERLEAVE [16] = '{
    4'h0,4'h7,4'hE,4'h6,4'hD,4'h5,4'hC,4'h4,
    4'hB,4'h3,4'hA,4'h2,4'h9,4'h1,4'h8,4'hF
  };

  // swap the two low bits of a byte
  function automatic logic [1:0] swap2(input logic [7:0] b);
    return {b[0], b[1]};
  endfunction

endpackage

// ===== rtl/gcr62_in_if.sv =====
// input channel: command beats with load or read payload
interface gcr62_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [11:0] store_index;
  logic [7:0]  store_byte;
  logic [7:0]  track;

  modport source (output valid, command, store_index, store_byte, track, input ready);
  modport sink   (input valid, command, store_index, store_byte, track, output ready);
endinterface

// ===== rtl/gcr62_out_if.sv =====
// result channel: encoded disk bytes
interface gcr62_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] disk_byte;
  logic       end_of_track;

  modport source (output valid, disk_byte, end_of_track, input ready);
  modport sink   (input valid, disk_byte, end_of_track, output ready);
endinterface

// ===== rtl/gcr_six_and_two_track_encoder_core.sv =====
// top level of the 6-and-2 group coded track encoder
// A load beat writes one byte into the 4096 x 8 track store; loads can follow each other
// with no gap while the sequencer is idle. A read beat returns the next disk byte of the
// track. The beat is taken in S_IDLE; S_DIV then splits the stream position into sector
// and offset by repeated subtraction of the sector length, one step per sector skipped
// (up to 15), plus one more step to settle the offset. Then come the decode state S_DEC,
// up to three reads of the track store for an auxiliary nibble (one for a data nibble) in
// S_RD and the S_PUT state to load the output register. Sync bytes of gap 1 skip the decode
// and the reads. The input is taken again as soon as the byte sits in the output register.
// A second read then stalls in the handoff state until the first byte is taken. The store
// has no reset.
module gcr_six_and_two_track_encoder_core
  import gcr62_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  gcr62_in_if.sink    in_ch,
  gcr62_out_if.source out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [7:0]  cfg_data
);

  localparam int DEPTH = SECTORS * SECTOR_BYTES;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_DEC, S_RD, S_PUT} state_t;

  state_t      state_r;
  logic [7:0]  volume_r, gap1_r, gap2_r, gap3_r;
  logic [13:0] pos_r, work_r;
  logic [7:0]  cur_trk_r;
  logic [5:0]  prev_r, nib_r;
  logic [9:0]  rem_r;
  logic [3:0]  sec_r, lg_r;
  logic        aux_r;
  logic [6:0]  kidx_r;
  logic [1:0]  step_r;
  logic [7:0]  res_byte_r;
  logic        res_eot_r;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_eot_r;

  logic [7:0]  mem [DEPTH];
  logic [7:0]  rdata_r;

  logic [9:0]  sec_len_c;
  logic [13:0] trk_len_c, pos_c, pos_inc_c;
  logic        acc_c, acc_rd_c;
  logic [AW-1:0] rd_addr_c;

  // decode temporaries
  logic [9:0]  r2_c, r3_c, d_c;
  logic [3:0]  a_c;
  logic [7:0]  av_c, ab_c;
  logic [7:0]  off_c;
  logic [3:0]  lg_c;
  logic [1:0]  sw_c;
  logic [5:0]  nib_c;
  logic        rd_done_c;

  assign sec_len_c = FIXED_PER_SECTOR + {2'b0, gap2_r} + {2'b0, gap3_r};
  assign trk_len_c = {sec_len_c, 4'b0} + {6'b0, gap1_r};
  assign pos_c     = (pos_r >= trk_len_c) ? '0 : pos_r;
  assign pos_inc_c = pos_c + 14'd1;
  assign acc_c     = in_ch.valid && in_ch.ready;
  assign acc_rd_c  = acc_c && (in_ch.command == CMD_READ);
  assign in_ch.ready = (state_r == S_IDLE);

  assign out_ch.valid        = out_valid_r;
  assign out_ch.disk_byte    = out_byte_r;
  assign out_ch.end_of_track = out_eot_r;

  // sector field decode and address-field byte
  always_comb begin
    r2_c  = rem_r - 10'd14;
    r3_c  = r2_c - {2'b0, gap2_r};
    d_c   = r3_c - 10'd3;
    a_c   = rem_r[3:0] - 4'd3;
    unique case (a_c[2:1])
      2'd0: av_c = volume_r;
      2'd1: av_c = cur_trk_r;
      2'd2: av_c = {4'b0, sec_r};
      default: av_c = volume_r ^ cur_trk_r ^ {4'b0, sec_r};
    endcase
    ab_c  = a_c[0] ? ((av_c & ODD_EVEN_M) | MARK_AA)
                   : (((av_c >> 1) & ODD_EVEN_M) | MARK_AA);
    lg_c  = INTERLEAVE[sec_r];
    off_c = (d_c < {3'b0, AUX_NIBBLES}) ? d_c[7:0] : 8'(d_c - {3'b0, AUX_NIBBLES});
    sw_c  = swap2(rdata_r);
    if (aux_r) begin
      unique case (step_r)
        2'd0: nib_c = {4'b0, sw_c};
        2'd1: nib_c = nib_r | {2'b0, sw_c, 2'b0};
        default: nib_c = nib_r | {sw_c, 4'b0};
      endcase
    end else begin
      nib_c = rdata_r[7:2];
    end
    rd_done_c = !aux_r || (step_r == 2'd2) ||
                ((step_r == 2'd1) && (kidx_r >= AUX_LAST_THIRD));
  end

  // store read address
  always_comb begin
    if (state_r == S_DEC) begin
      rd_addr_c = AW'({lg_c, off_c});
    end else if (step_r == 2'd0) begin
      rd_addr_c = AW'({lg_r, 8'({1'b0, kidx_r} + AUX_STEP)});
    end else begin
      rd_addr_c = AW'({lg_r, 8'({1'b0, kidx_r} + AUX_STEP + AUX_STEP)});
    end
  end

  // track store
  always_ff @(posedge clk) begin
    if (acc_c && (in_ch.command == CMD_LOAD)) begin
      mem[in_ch.store_index[AW-1:0]] <= in_ch.store_byte;
    end
    rdata_r <= mem[rd_addr_c];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volume_r <= RST_VOLUME;
      gap1_r   <= RST_GAP1;
      gap2_r   <= RST_GAP2;
      gap3_r   <= RST_GAP3;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_VOLUME: volume_r <= cfg_data;
        REG_GAP1:   gap1_r   <= cfg_data;
        REG_GAP2:   gap2_r   <= cfg_data;
        default:    gap3_r   <= cfg_data;
      endcase
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      cur_trk_r   <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      if (out_valid_r && out_ch.ready && (state_r != S_PUT)) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (acc_rd_c) begin
            work_r <= pos_c;
            if (pos_c == '0) cur_trk_r <= in_ch.track;
            if (pos_inc_c >= trk_len_c) begin
              pos_r     <= '0;
              res_eot_r <= 1'b1;
            end else begin
              pos_r     <= pos_inc_c;
              res_eot_r <= 1'b0;
            end
            state_r <= S_DIV;
            sec_r   <= '0;
            rem_r   <= '0;
          end
        end
        S_DIV: begin
          // position split into sector and offset, one subtraction a cycle
          if (work_r < {6'b0, gap1_r}) begin
            res_byte_r <= SYNC_BYTE;
            state_r    <= S_PUT;
          end else if ((work_r - {6'b0, gap1_r}) >= {4'b0, sec_len_c}) begin
            work_r <= work_r - {4'b0, sec_len_c};
            sec_r  <= sec_r + 4'd1;
          end else begin
            rem_r   <= 10'(work_r - {6'b0, gap1_r});
            state_r <= S_DEC;
          end
        end
        S_DEC: begin
          state_r <= S_PUT;
          if (rem_r < 10'd3) begin
            unique case (rem_r[1:0])
              2'd0: res_byte_r <= MARK_D5;
              2'd1: res_byte_r <= MARK_AA;
              default: res_byte_r <= MARK_ADDR;
            endcase
          end else if (rem_r < 10'd11) begin
            res_byte_r <= ab_c;
          end else if (rem_r < 10'd14) begin
            unique case (rem_r[1:0])
              2'd3: res_byte_r <= MARK_DE;
              2'd0: res_byte_r <= MARK_AA;
              default: res_byte_r <= MARK_EB;
            endcase
          end else if (r2_c < {2'b0, gap2_r}) begin
            res_byte_r <= SYNC_BYTE;
          end else if (r3_c < 10'd3) begin
            prev_r <= '0;
            unique case (r3_c[1:0])
              2'd0: res_byte_r <= MARK_D5;
              2'd1: res_byte_r <= MARK_AA;
              default: res_byte_r <= MARK_DATA;
            endcase
          end else if (d_c < DATA_NIBBLES) begin
            // nibble fetch from the store
            aux_r   <= (d_c < {3'b0, AUX_NIBBLES});
            kidx_r  <= d_c[6:0];
            lg_r    <= lg_c;
            nib_r   <= '0;
            step_r  <= '0;
            state_r <= S_RD;
          end else if (d_c == DATA_NIBBLES) begin
            res_byte_r <= GCR_TABLE[prev_r];
          end else if (d_c < DATA_NIBBLES + 10'd4) begin
            unique case (d_c[1:0])
              2'd3: res_byte_r <= MARK_DE;
              2'd0: res_byte_r <= MARK_AA;
              default: res_byte_r <= MARK_EB;
            endcase
          end else begin
            res_byte_r <= SYNC_BYTE;
          end
        end
        S_RD: begin
          nib_r  <= nib_c;
          step_r <= rd_done_c ? 2'd0 : step_r + 2'd1;
          if (rd_done_c) begin
            res_byte_r <= GCR_TABLE[nib_c ^ prev_r];
            prev_r     <= nib_c;
            state_r    <= S_PUT;
          end
        end
        S_PUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_byte_r  <= res_byte_r;
            out_eot_r   <= res_eot_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // end of track flag agrees with the position wrap
  a_eot_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    acc_rd_c |=> (res_eot_r == (pos_r == '0)))
    else $error("end of track flag does not match position wrap");

  // sector search never runs past the last sector
  a_sec_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) && (sec_r == 4'd15) && (work_r >= {6'b0, gap1_r}) |->
      ((work_r - {6'b0, gap1_r}) < {4'b0, sec_len_c}))
    else $error("sector search overran the track");

  // a data nibble takes a single store read
  a_one_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) && !aux_r |=> (state_r == S_PUT))
    else $error("data nibble fetch did not finish");

endmodule
